// ===== design/tsrsm_pkg.sv =====
`timescale 1ns / 1ps

package tsrsm_pkg;

  // Widths fixed by the item format.
  localparam int unsigned ELEM_W = 9;
  localparam int unsigned BIT_W  = 4;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // Move codes of a result transaction.
  localparam logic [1:0] MV_RA   = 2'd0;
  localparam logic [1:0] MV_PB   = 2'd1;
  localparam logic [1:0] MV_PA   = 2'd2;
  localparam logic [1:0] MV_NONE = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic idle;
    logic load;
    logic clear;
    logic resolve;
    logic read;
    logic exec;
  } dp_cmd_t;

  // Number of significant bits in an element value.
  function automatic logic [BIT_W-1:0] bit_length(input logic [ELEM_W-1:0] v);
    logic [BIT_W-1:0] n;
    n = '0;
    for (int i = 0; i < ELEM_W; i++) begin
      if (v[i]) begin
        n = BIT_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// ===== design/two_stack_radix_sort_moves.sv =====
`timescale 1ns / 1ps
// Load and clear transactions go through their own step state and return to idle before the next accept.
// An advance steps through resolve phase, memory read and execute, then idle;
// its result strobes for one cycle, registered at the end of the execute step.
// The rate is set by the registered read of the stack memories in each move.
// Reset clears all counters and the phase; the stack memories are not cleared.
module two_stack_radix_sort_moves #(
  parameter int unsigned MAX_ITEMS = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   op_i,
  input  logic [tsrsm_pkg::ELEM_W-1:0] element_index_i,
  output logic                         result_valid_o,
  output logic [1:0]                   move_o,
  output logic [tsrsm_pkg::ELEM_W-1:0] moved_index_o,
  output logic                         last_move_o
);
  import tsrsm_pkg::*;

  dp_cmd_t cmd;

  // Sequencer for the steps of each transaction.
  tsrsm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // Stacks, sort state and result registers.
  tsrsm_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .element_index_i (element_index_i),
    .result_valid_o  (result_valid_o),
    .move_o          (move_o),
    .moved_index_o   (moved_index_o),
    .last_move_o     (last_move_o)
  );

endmodule

// ===== design/tsrsm_ctrl.sv =====
`timescale 1ns / 1ps

module tsrsm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [1:0]       op_i,
  output logic             busy,
  output tsrsm_pkg::dp_cmd_t cmd_o
);
  import tsrsm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CLEAR,
    ST_RESOLVE,
    ST_READ,
    ST_EXEC
  } state_e;

  state_e  state_q;
  dp_cmd_t cmd_q, cmd_d;
  logic    busy_q;

  // Next command for each step; idle is raised while waiting.
  always_comb begin
    cmd_d = '{default: 1'b0};
    unique case (state_q) inside
      ST_IDLE: begin
        cmd_d.idle = 1'b1;
        if (start) begin
          unique case (op_i)
            OP_LOAD: begin
              cmd_d.idle = 1'b0;
              cmd_d.load = 1'b1;
            end
            OP_ADVANCE: begin
              cmd_d.idle    = 1'b0;
              cmd_d.resolve = 1'b1;
            end
            OP_CLEAR: begin
              cmd_d.idle  = 1'b0;
              cmd_d.clear = 1'b1;
            end
            default: begin
              cmd_d.idle = 1'b1;
            end
          endcase
        end
      end
      ST_RESOLVE: begin
        cmd_d.read = 1'b1;
      end
      ST_READ: begin
        cmd_d.exec = 1'b1;
      end
      ST_LOAD, ST_CLEAR, ST_EXEC: begin
        cmd_d.idle = 1'b1;
      end
      default: begin
        cmd_d.idle = 1'b1;
      end
    endcase
  end

  // Sequencer: one command per cycle, back to idle after the last step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      cmd_q   <= '{idle: 1'b1, default: 1'b0};
    end else begin
      cmd_q <= cmd_d;
      unique case (state_q) inside
        ST_IDLE: begin
          if (start) begin
            unique case (op_i)
              OP_LOAD: begin
                state_q <= ST_LOAD;
                busy_q  <= 1'b1;
              end
              OP_ADVANCE: begin
                state_q <= ST_RESOLVE;
                busy_q  <= 1'b1;
              end
              OP_CLEAR: begin
                state_q <= ST_CLEAR;
                busy_q  <= 1'b1;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_RESOLVE: begin
          state_q <= ST_READ;
        end
        ST_READ: begin
          state_q <= ST_EXEC;
        end
        ST_LOAD, ST_CLEAR, ST_EXEC: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy  = busy_q;
  assign cmd_o = cmd_q;

endmodule

// ===== design/tsrsm_dp.sv =====
`timescale 1ns / 1ps

module tsrsm_dp #(
  parameter int unsigned MAX_ITEMS = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tsrsm_pkg::dp_cmd_t           cmd_i,
  input  logic [tsrsm_pkg::ELEM_W-1:0] element_index_i,
  output logic                         result_valid_o,
  output logic [1:0]                   move_o,
  output logic [tsrsm_pkg::ELEM_W-1:0] moved_index_o,
  output logic                         last_move_o
);
  import tsrsm_pkg::*;

  localparam int unsigned PW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ITEMS);
  localparam logic [PW-1:0] LastSlot = PW'(MAX_ITEMS - 1);

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_SCAN,
    PH_BACK,
    PH_DONE
  } phase_e;

  // Circular slot arithmetic on the stack A buffer.
  function automatic logic [PW-1:0] slot_add(input logic [PW-1:0] p, input logic [CW-1:0] n);
    logic [CW:0] s;
    s = (CW+1)'(p) + (CW+1)'(n);
    if (s >= (CW+1)'(MAX_ITEMS)) begin
      s = s - (CW+1)'(MAX_ITEMS);
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == LastSlot) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] p);
    return (p == '0) ? LastSlot : p - PW'(1);
  endfunction

  // Sort state.
  logic [PW-1:0]     top_q, top_d;
  logic [CW-1:0]     a_cnt_q, a_cnt_d;
  logic [CW-1:0]     b_cnt_q, b_cnt_d;
  logic [CW-1:0]     scan_q, scan_d;
  logic [ELEM_W-1:0] largest_q, largest_d;
  logic [BIT_W-1:0]  bit_pass_q, bit_pass_d;
  phase_e            phase_q, phase_d;

  // Captured element and memory read data.
  logic [ELEM_W-1:0] elem_q;
  logic [ELEM_W-1:0] a_rd_q;
  logic [ELEM_W-1:0] b_rd_q;

  // Result registers.
  logic              res_valid_q;
  logic [1:0]        move_q, move_d;
  logic [ELEM_W-1:0] res_idx_q, res_idx_d;
  logic              last_q, last_d;

  // Memory ports.
  logic              a_we, b_we;
  logic [PW-1:0]     a_waddr, b_waddr;
  logic [ELEM_W-1:0] a_wdata;
  logic [CW-1:0]     b_dec;
  logic [PW-1:0]     b_raddr;

  logic [ELEM_W-1:0] stack_a_mem [MAX_ITEMS];
  logic [ELEM_W-1:0] stack_b_mem [MAX_ITEMS];

  assign b_dec   = b_cnt_q - CW'(1);
  assign b_raddr = b_dec[PW-1:0];

  // Next-state logic for load, resolve and execute steps.
  always_comb begin
    logic [ELEM_W-1:0] val;
    logic [ELEM_W-1:0] shifted;
    logic              end_pass;

    top_d      = top_q;
    a_cnt_d    = a_cnt_q;
    b_cnt_d    = b_cnt_q;
    scan_d     = scan_q;
    largest_d  = largest_q;
    bit_pass_d = bit_pass_q;
    phase_d    = phase_q;
    a_we       = 1'b0;
    a_waddr    = top_q;
    a_wdata    = elem_q;
    b_we       = 1'b0;
    b_waddr    = b_cnt_q[PW-1:0];
    move_d     = MV_NONE;
    res_idx_d  = '0;
    last_d     = 1'b0;
    val        = '0;
    shifted    = '0;
    end_pass   = 1'b0;

    if (cmd_i.load) begin
      // Append at the bottom of A while loading and not full.
      if (phase_q == PH_LOAD && a_cnt_q < MaxCount) begin
        a_we    = 1'b1;
        a_waddr = slot_add(top_q, a_cnt_q);
        a_wdata = elem_q;
        a_cnt_d = a_cnt_q + CW'(1);
        if (elem_q > largest_q) begin
          largest_d = elem_q;
        end
      end
    end else if (cmd_i.resolve) begin
      // Leave the loading phase on the first advance.
      if (phase_q == PH_LOAD) begin
        bit_pass_d = '0;
        if (a_cnt_q == '0 || largest_q == '0) begin
          phase_d = PH_DONE;
        end else begin
          scan_d  = a_cnt_q;
          phase_d = PH_SCAN;
        end
      end
      // A scan with nothing left to examine ends at once: back phase if B holds items, else the pass closes.
      if (phase_d == PH_SCAN && (scan_d == '0 || a_cnt_q == '0)) begin
        if (b_cnt_q != '0) begin
          phase_d = PH_BACK;
        end else begin
          bit_pass_d = bit_pass_d + BIT_W'(1);
          if (bit_pass_d >= bit_length(largest_q)) begin
            phase_d = PH_DONE;
          end else begin
            scan_d  = a_cnt_q;
            phase_d = PH_SCAN;
          end
        end
      end
    end else if (cmd_i.exec) begin
      case (phase_q)
        PH_SCAN: begin
          val     = a_rd_q;
          shifted = val >> bit_pass_q;
          if (shifted[0]) begin
            move_d  = MV_RA;
            a_we    = 1'b1;
            a_waddr = slot_add(top_q, a_cnt_q);
            a_wdata = val;
            top_d   = wrap_inc(top_q);
          end else begin
            move_d = MV_PB;
            if (b_cnt_q < MaxCount) begin
              b_we    = 1'b1;
              b_cnt_d = b_cnt_q + CW'(1);
            end
            top_d   = wrap_inc(top_q);
            a_cnt_d = a_cnt_q - CW'(1);
          end
          scan_d = scan_q - CW'(1);
          if (scan_d == '0) begin
            if (b_cnt_d != '0) begin
              phase_d = PH_BACK;
            end else begin
              end_pass = 1'b1;
            end
          end
        end
        PH_BACK: begin
          move_d  = MV_PA;
          val     = b_rd_q;
          b_cnt_d = b_cnt_q - CW'(1);
          top_d   = wrap_dec(top_q);
          a_we    = 1'b1;
          a_waddr = top_d;
          a_wdata = val;
          a_cnt_d = a_cnt_q + CW'(1);
          if (b_cnt_d == '0) begin
            end_pass = 1'b1;
          end
        end
        default: begin
          move_d = MV_NONE;
        end
      endcase
      // Close a bit pass: next bit or finished.
      if (end_pass) begin
        bit_pass_d = bit_pass_q + BIT_W'(1);
        if (bit_pass_d >= bit_length(largest_q)) begin
          phase_d = PH_DONE;
        end else begin
          scan_d  = a_cnt_d;
          phase_d = PH_SCAN;
        end
      end
      res_idx_d = (move_d == MV_NONE) ? '0 : val;
      last_d    = (move_d != MV_NONE) && (phase_d == PH_DONE);
    end
  end

  // Sort state registers; the clear command returns them to reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      a_cnt_q     <= '0;
      b_cnt_q     <= '0;
      scan_q      <= '0;
      largest_q   <= '0;
      bit_pass_q  <= '0;
      phase_q     <= PH_LOAD;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.exec;
      if (cmd_i.clear) begin
        top_q      <= '0;
        a_cnt_q    <= '0;
        b_cnt_q    <= '0;
        scan_q     <= '0;
        largest_q  <= '0;
        bit_pass_q <= '0;
        phase_q    <= PH_LOAD;
      end else begin
        top_q      <= top_d;
        a_cnt_q    <= a_cnt_d;
        b_cnt_q    <= b_cnt_d;
        scan_q     <= scan_d;
        largest_q  <= largest_d;
        bit_pass_q <= bit_pass_d;
        phase_q    <= phase_d;
      end
    end
  end

  // Payload registers: captured element and result fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.idle) begin
      elem_q <= element_index_i;
    end
    if (cmd_i.exec) begin
      move_q    <= move_d;
      res_idx_q <= res_idx_d;
      last_q    <= last_d;
    end
  end

  // Stack A memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (a_we) begin
      stack_a_mem[a_waddr] <= a_wdata;
    end
    if (cmd_i.read) begin
      a_rd_q <= stack_a_mem[top_q];
    end
  end

  // Stack B memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (b_we) begin
      stack_b_mem[b_waddr] <= a_rd_q;
    end
    if (cmd_i.read) begin
      b_rd_q <= stack_b_mem[b_raddr];
    end
  end

  assign result_valid_o = res_valid_q;
  assign move_o         = move_q;
  assign moved_index_o  = res_idx_q;
  assign last_move_o    = last_q;

endmodule
